// ===== design/qppr_pkg.sv =====
// shared types and constants for the quad parallel port register board
// no dependencies; used by every module of the block
`default_nettype none

package qppr_pkg;

    localparam int MAX_PORTS_DEF = 4;

    localparam int TYPE_W = 2;
    localparam int ADDR_W = 8;
    localparam int BYTE_W = 8;
    localparam int SECT_W = 3;
    localparam int CTL_W  = 6;
    localparam int PORTS_W = 3;
    localparam int CFG_IDX_W = 2;

    // request codes
    localparam logic [TYPE_W-1:0] REQ_READ   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_WRITE  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_ARRIVE = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_CLEAR  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORTS  = 2'd2;

    // control bit that steers data accesses to latch / output
    localparam int CTL_DATA_SELECT_BIT = 2;
    localparam logic [BYTE_W-1:0] STATUS_FULL = 8'h80;
    localparam logic [BYTE_W-1:0] CTL_KEEP    = 8'h3F;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [ADDR_W-1:0] io_address;
        logic [BYTE_W-1:0] write_data;
        logic [SECT_W-1:0] arrive_section;
        logic [BYTE_W-1:0] arrive_byte;
    } item_t;

    typedef struct packed {
        logic              hit;
        logic              rd;
        logic              wr;
        logic              is_data;
        logic              arrive;
        logic              clear;
        logic [SECT_W-1:0] sec;
    } dec_t;

    typedef struct packed {
        logic              hit;
        logic [BYTE_W-1:0] read_data;
        logic              out_valid;
        logic [SECT_W-1:0] out_section;
        logic [BYTE_W-1:0] out_byte;
        logic              arrive_taken;
    } rsp_t;

endpackage

`default_nettype wire

// ===== design/quad_parallel_port_registers.sv =====
// path: each word goes through the input register, then the result register
// throughput: one word per cycle unless rsp_ready holds the output; the section update and
// the result are both done in the single pass from the input register to the result register
// reset: section state cleared, board_enable 1, base_address 0, ports_fitted 1
// depends on qppr_pkg, qppr_decode, qppr_sections
`default_nettype none

module quad_parallel_port_registers #(
    parameter int MAX_PORTS = qppr_pkg::MAX_PORTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire logic [qppr_pkg::TYPE_W-1:0]     req_type,
    input  wire logic [qppr_pkg::ADDR_W-1:0]     io_address,
    input  wire logic [qppr_pkg::BYTE_W-1:0]     write_data,
    input  wire logic [qppr_pkg::SECT_W-1:0]     arrive_section,
    input  wire logic [qppr_pkg::BYTE_W-1:0]     arrive_byte,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output logic                                 hit,
    output logic [qppr_pkg::BYTE_W-1:0]          read_data,
    output logic                                 out_valid,
    output logic [qppr_pkg::SECT_W-1:0]          out_section,
    output logic [qppr_pkg::BYTE_W-1:0]          out_byte,
    output logic                                 arrive_taken,
    input  wire logic                            cfg_we,
    input  wire logic [qppr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [qppr_pkg::ADDR_W-1:0]     cfg_data
);

    logic                           enable_reg;
    logic [qppr_pkg::ADDR_W-1:0]    base_reg;
    logic [qppr_pkg::PORTS_W-1:0]   ports_reg;

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    qppr_pkg::item_t                s1_item_reg;
    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;
    qppr_pkg::rsp_t                 result_reg;

    qppr_pkg::dec_t                 dec;
    qppr_pkg::rsp_t                 result;
    logic                           out_free;
    logic                           s1_fire;
    logic                           in_fire;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign req_ready = !s1_valid_reg || out_free;
    assign in_fire   = req_valid && req_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (s1_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b1;
            base_reg      <= '0;
            ports_reg     <= qppr_pkg::PORTS_W'(1);
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    qppr_pkg::CFG_ENABLE: enable_reg <= cfg_data[0];
                    qppr_pkg::CFG_BASE:   base_reg   <= cfg_data;
                    qppr_pkg::CFG_PORTS:  ports_reg  <= cfg_data[qppr_pkg::PORTS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.req_type       <= req_type;
            s1_item_reg.io_address     <= io_address;
            s1_item_reg.write_data     <= write_data;
            s1_item_reg.arrive_section <= arrive_section;
            s1_item_reg.arrive_byte    <= arrive_byte;
        end
        if (s1_fire)
        begin
            result_reg <= result;
        end
    end

    qppr_decode #(
        .MAX_PORTS(MAX_PORTS)
    ) u_decode (
        .board_enable(enable_reg),
        .base_address(base_reg),
        .ports_fitted(ports_reg),
        .item        (s1_item_reg),
        .dec         (dec)
    );

    qppr_sections #(
        .MAX_PORTS(MAX_PORTS)
    ) u_sections (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (s1_fire),
        .item (s1_item_reg),
        .dec  (dec),
        .rsp  (result)
    );

    assign rsp_valid    = rsp_valid_reg;
    assign hit          = result_reg.hit;
    assign read_data    = result_reg.read_data;
    assign out_valid    = result_reg.out_valid;
    assign out_section  = result_reg.out_section;
    assign out_byte     = result_reg.out_byte;
    assign arrive_taken = result_reg.arrive_taken;

    // an emitted byte only comes from a decoded access
    a_emit_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && result_reg.out_valid |-> result_reg.hit)
        else $error("emitted byte without window hit");

    // an io access and an arrival never both report
    a_hit_xor_taken: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(result_reg.hit && result_reg.arrive_taken))
        else $error("hit and arrive_taken both set");

    // board reset gives an all-zero word
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_item_reg.req_type == qppr_pkg::REQ_CLEAR) |=> (result_reg == '0))
        else $error("board reset result not zero");

    // input only stalls when both stages are held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> s1_valid_reg && rsp_valid_reg && !rsp_ready)
        else $error("input stalled without a full pipe");

endmodule

`default_nettype wire

// ===== design/qppr_decode.sv =====
// address window decode and request classification
// depends on qppr_pkg
`default_nettype none

module qppr_decode #(
    parameter int MAX_PORTS = qppr_pkg::MAX_PORTS_DEF
) (
    input  wire logic                          board_enable,
    input  wire logic [qppr_pkg::ADDR_W-1:0]   base_address,
    input  wire logic [qppr_pkg::PORTS_W-1:0]  ports_fitted,
    input  wire qppr_pkg::item_t               item,
    output qppr_pkg::dec_t                     dec
);

    localparam logic [qppr_pkg::PORTS_W-1:0] MAXP = qppr_pkg::PORTS_W'(MAX_PORTS);

    logic [qppr_pkg::PORTS_W-1:0] live;
    logic [qppr_pkg::ADDR_W:0]    off;
    logic [qppr_pkg::PORTS_W+1:0] win_len;
    logic                         in_win;
    logic                         is_io;

    always_comb
    begin
        live    = (ports_fitted > MAXP) ? MAXP : ports_fitted;
        // borrow out of the subtract means below base
        off     = {1'b0, item.io_address} - {1'b0, base_address};
        win_len = {live, 2'b00};
        in_win  = !off[qppr_pkg::ADDR_W]
                  && (off[qppr_pkg::ADDR_W-1:0] < qppr_pkg::ADDR_W'(win_len));
        is_io   = (item.req_type == qppr_pkg::REQ_READ)
                  || (item.req_type == qppr_pkg::REQ_WRITE);

        dec.hit     = board_enable && is_io && in_win;
        dec.rd      = dec.hit && (item.req_type == qppr_pkg::REQ_READ);
        dec.wr      = dec.hit && (item.req_type == qppr_pkg::REQ_WRITE);
        dec.is_data = off[0];
        dec.clear   = (item.req_type == qppr_pkg::REQ_CLEAR);
        // arrivals only reach fitted sections
        dec.arrive  = (item.req_type == qppr_pkg::REQ_ARRIVE)
                      && ({1'b0, item.arrive_section} < {live, 1'b0});
        if (item.req_type == qppr_pkg::REQ_ARRIVE)
        begin
            dec.sec = item.arrive_section;
        end
        else
        begin
            dec.sec = {off[3:2], off[1]};
        end
    end

endmodule

`default_nettype wire

// ===== design/qppr_sections.sv =====
// per-section register file: control, direction, output, input latch, full flag
// depends on qppr_pkg; fed by qppr_decode
`default_nettype none

module qppr_sections #(
    parameter int MAX_PORTS = qppr_pkg::MAX_PORTS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire qppr_pkg::item_t item,
    input  wire qppr_pkg::dec_t  dec,
    output qppr_pkg::rsp_t       rsp
);

    localparam int NSEC  = 2 * MAX_PORTS;
    localparam int SEC_W = $clog2(NSEC);

    logic [qppr_pkg::CTL_W-1:0]  ctl_reg   [NSEC];
    logic [qppr_pkg::CTL_W-1:0]  ctl_next  [NSEC];
    logic [qppr_pkg::BYTE_W-1:0] dir_reg   [NSEC];
    logic [qppr_pkg::BYTE_W-1:0] dir_next  [NSEC];
    logic [qppr_pkg::BYTE_W-1:0] obyte_reg [NSEC];
    logic [qppr_pkg::BYTE_W-1:0] obyte_next[NSEC];
    logic [qppr_pkg::BYTE_W-1:0] latch_reg [NSEC];
    logic [qppr_pkg::BYTE_W-1:0] latch_next[NSEC];
    logic [NSEC-1:0]             full_reg;
    logic [NSEC-1:0]             full_next;

    logic [SEC_W-1:0]            sel;
    logic                        dsel;

    always_comb
    begin
        ctl_next   = ctl_reg;
        dir_next   = dir_reg;
        obyte_next = obyte_reg;
        latch_next = latch_reg;
        full_next  = full_reg;
        rsp        = '0;
        sel        = dec.sec[SEC_W-1:0];
        dsel       = ctl_reg[sel][qppr_pkg::CTL_DATA_SELECT_BIT];

        if (dec.clear)
        begin
            for (int i = 0; i < NSEC; i++)
            begin
                ctl_next[i]   = '0;
                dir_next[i]   = '0;
                obyte_next[i] = '0;
                latch_next[i] = '0;
            end
            full_next = '0;
        end
        else if (dec.rd)
        begin
            rsp.hit = 1'b1;
            if (!dec.is_data)
            begin
                rsp.read_data = qppr_pkg::BYTE_W'(ctl_reg[sel])
                                | (full_reg[sel] ? qppr_pkg::STATUS_FULL : '0);
            end
            else if (dsel)
            begin
                rsp.read_data  = latch_reg[sel];
                full_next[sel] = 1'b0;
            end
            else
            begin
                rsp.read_data = dir_reg[sel];
            end
        end
        else if (dec.wr)
        begin
            rsp.hit = 1'b1;
            if (!dec.is_data)
            begin
                ctl_next[sel] = qppr_pkg::CTL_W'(item.write_data & qppr_pkg::CTL_KEEP);
            end
            else if (dsel)
            begin
                obyte_next[sel] = item.write_data;
                rsp.out_valid   = 1'b1;
                rsp.out_section = dec.sec;
                rsp.out_byte    = item.write_data;
            end
            else
            begin
                dir_next[sel] = item.write_data;
            end
        end
        else if (dec.arrive && !full_reg[sel])
        begin
            latch_next[sel]  = item.arrive_byte;
            full_next[sel]   = 1'b1;
            rsp.arrive_taken = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSEC; i++)
            begin
                ctl_reg[i]   <= '0;
                dir_reg[i]   <= '0;
                obyte_reg[i] <= '0;
                latch_reg[i] <= '0;
            end
            full_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg   <= ctl_next;
            dir_reg   <= dir_next;
            obyte_reg <= obyte_next;
            latch_reg <= latch_next;
            full_reg  <= full_next;
        end
    end

endmodule

`default_nettype wire

// ===== test/quad_parallel_port_registers_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for quad_parallel_port_registers: drives bus accesses, arriving
// bytes and board resets, predicts each reply from its own copy of the section state
// depends on qppr_pkg and the quad_parallel_port_registers rtl

module quad_parallel_port_registers_tb;

    import qppr_pkg::*;

    localparam int SECTIONS    = 2 * MAX_PORTS_DEF;
    localparam int STALL_LIMIT = 5000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    logic [TYPE_W-1:0]    req_type = REQ_READ;
    logic [ADDR_W-1:0]    io_address = '0;
    logic [BYTE_W-1:0]    write_data = '0;
    logic [SECT_W-1:0]    arrive_section = '0;
    logic [BYTE_W-1:0]    arrive_byte = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    logic                 hit;
    logic [BYTE_W-1:0]    read_data;
    logic                 out_valid;
    logic [SECT_W-1:0]    out_section;
    logic [BYTE_W-1:0]    out_byte;
    logic                 arrive_taken;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ENABLE;
    logic [ADDR_W-1:0]    cfg_data = '0;

    quad_parallel_port_registers dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_type       (req_type),
        .io_address     (io_address),
        .write_data     (write_data),
        .arrive_section (arrive_section),
        .arrive_byte    (arrive_byte),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .hit            (hit),
        .read_data      (read_data),
        .out_valid      (out_valid),
        .out_section    (out_section),
        .out_byte       (out_byte),
        .arrive_taken   (arrive_taken),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // board registers as last programmed
    logic               board_on = 1'b1;
    logic [ADDR_W-1:0]  window_base = '0;
    logic [PORTS_W-1:0] ports_set = 3'd1;

    // section state
    logic [CTL_W-1:0]   sect_ctl   [SECTIONS];
    logic [BYTE_W-1:0]  sect_dir   [SECTIONS];
    logic [BYTE_W-1:0]  sect_out   [SECTIONS];
    logic [BYTE_W-1:0]  sect_latch [SECTIONS];
    logic               sect_full  [SECTIONS];

    item_t bus_words [$];
    rsp_t  expected_replies [$];
    item_t held_word;
    int    sender_idle_pct = 0;
    int    receiver_idle_pct = 0;
    int    mismatches = 0;
    int    quiet_cycles = 0;

    function automatic int unsigned live_ports();
        return (ports_set > MAX_PORTS_DEF) ? MAX_PORTS_DEF : ports_set;
    endfunction

    function automatic void clear_sections();
        foreach (sect_ctl[i])
        begin
            sect_ctl[i]   = '0;
            sect_dir[i]   = '0;
            sect_out[i]   = '0;
            sect_latch[i] = '0;
            sect_full[i]  = 1'b0;
        end
    endfunction

    // reply of the board to one word, updating the section state on the way
    function automatic rsp_t board_access(item_t w);
        rsp_t        r;
        int unsigned live, addr, base, off, sec;
        logic        is_data;
        r = '0;
        live = live_ports();
        addr = w.io_address;
        base = window_base;
        case (w.req_type)
            REQ_READ, REQ_WRITE:
            begin
                // window end is base + 4 * ports with no wrap
                if (board_on && addr >= base && addr < base + 4 * live)
                begin
                    off = addr - base;
                    sec = ((off >> 2) * 2 + ((off >> 1) & 1)) % SECTIONS;
                    is_data = off[0];
                    r.hit = 1'b1;
                    if (w.req_type == REQ_READ)
                    begin
                        if (!is_data)
                            r.read_data = ({2'b00, sect_ctl[sec]} & CTL_KEEP)
                                          | (sect_full[sec] ? STATUS_FULL : '0);
                        else if (sect_ctl[sec][CTL_DATA_SELECT_BIT])
                        begin
                            sect_full[sec] = 1'b0;
                            r.read_data = sect_latch[sec];
                        end
                        else
                            r.read_data = sect_dir[sec];
                    end
                    else
                    begin
                        if (!is_data)
                            sect_ctl[sec] = w.write_data[CTL_W-1:0];
                        else if (sect_ctl[sec][CTL_DATA_SELECT_BIT])
                        begin
                            sect_out[sec] = w.write_data;
                            r.out_valid = 1'b1;
                            r.out_section = SECT_W'(sec);
                            r.out_byte = w.write_data;
                        end
                        else
                            sect_dir[sec] = w.write_data;
                    end
                end
            end
            REQ_ARRIVE:
            begin
                if (w.arrive_section < 2 * live && !sect_full[w.arrive_section])
                begin
                    sect_latch[w.arrive_section] = w.arrive_byte;
                    sect_full[w.arrive_section] = 1'b1;
                    r.arrive_taken = 1'b1;
                end
            end
            default:
                clear_sections();
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_replies.insert(expected_replies.size(), board_access(held_word));
            if (!req_valid || req_ready)
            begin
                if (bus_words.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    held_word = bus_words.pop_front();
                    req_valid      <= 1'b1;
                    req_type       <= held_word.req_type;
                    io_address     <= held_word.io_address;
                    write_data     <= held_word.write_data;
                    arrive_section <= held_word.arrive_section;
                    arrive_byte    <= held_word.arrive_byte;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("reply word with no access outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("hit", want.hit, hit);
                    check_field("read_data", want.read_data, read_data);
                    check_field("out_valid", want.out_valid, out_valid);
                    check_field("out_section", want.out_section, out_section);
                    check_field("out_byte", want.out_byte, out_byte);
                    check_field("arrive_taken", want.arrive_taken, arrive_taken);
                end
            end
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_word(logic [TYPE_W-1:0] kind, logic [ADDR_W-1:0] addr,
                             logic [BYTE_W-1:0] wdata, logic [SECT_W-1:0] sec,
                             logic [BYTE_W-1:0] abyte);
        item_t w;
        w.req_type = kind;
        w.io_address = addr;
        w.write_data = wdata;
        w.arrive_section = sec;
        w.arrive_byte = abyte;
        bus_words.insert(bus_words.size(), w);
    endtask

    function automatic item_t random_word();
        item_t       w;
        int unsigned live, span, off, roll;
        w.io_address = ADDR_W'($urandom_range(255));
        w.write_data = BYTE_W'($urandom_range(255));
        w.arrive_section = SECT_W'($urandom_range(7));
        w.arrive_byte = BYTE_W'($urandom_range(255));
        live = live_ports();
        span = 4 * live;
        roll = $urandom_range(99);
        if (roll < 2)
            w.req_type = REQ_CLEAR;
        else if (roll < 38)
            w.req_type = REQ_READ;
        else if (roll < 72)
            w.req_type = REQ_WRITE;
        else
            w.req_type = REQ_ARRIVE;
        // mostly aim at the window and at fitted sections
        if (span != 0 && $urandom_range(9) < 8)
        begin
            off = $urandom_range(span - 1);
            if (window_base + off <= 255)
                w.io_address = ADDR_W'(window_base + off);
        end
        if (live != 0 && $urandom_range(9) < 8)
            w.arrive_section = SECT_W'($urandom_range(2 * live - 1));
        return w;
    endfunction

    // wait until no word is in flight, then give the pipeline time to drain
    task automatic settle();
        while (bus_words.size() != 0 || req_valid || expected_replies.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic program_board(logic en, logic [ADDR_W-1:0] base, logic [PORTS_W-1:0] ports);
        settle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ENABLE;
        cfg_data  <= {{(ADDR_W-1){1'b0}}, en};
        @(posedge clk);
        cfg_index <= CFG_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= CFG_PORTS;
        cfg_data  <= {{(ADDR_W-PORTS_W){1'b0}}, ports};
        @(posedge clk);
        cfg_we    <= 1'b0;
        board_on = en;
        window_base = base;
        ports_set = ports;
    endtask

    initial
    begin
        clear_sections();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        sender_idle_pct = 12;
        receiver_idle_pct = 88;

        // reset setup: one port, window at address zero
        push_word(REQ_ARRIVE, 8'h00, 8'h00, 3'd0, 8'hFF);
        push_word(REQ_ARRIVE, 8'hFF, 8'hFF, 3'd0, 8'h00);   // latch already full
        push_word(REQ_ARRIVE, 8'h00, 8'h00, 3'd2, 8'hA5);   // section not fitted
        push_word(REQ_READ,   8'h00, 8'h00, 3'd0, 8'h00);   // status shows full
        push_word(REQ_WRITE,  8'h00, 8'hFF, 3'd0, 8'h00);   // top two bits dropped
        push_word(REQ_READ,   8'h00, 8'h00, 3'd0, 8'h00);
        push_word(REQ_READ,   8'h01, 8'h00, 3'd0, 8'h00);   // latch read clears full
        push_word(REQ_READ,   8'h00, 8'h00, 3'd0, 8'h00);
        push_word(REQ_WRITE,  8'h01, 8'hFF, 3'd7, 8'hFF);
        push_word(REQ_WRITE,  8'h02, 8'h00, 3'd0, 8'h00);
        push_word(REQ_WRITE,  8'h03, 8'hFF, 3'd0, 8'h00);   // direction byte
        push_word(REQ_READ,   8'h03, 8'h00, 3'd0, 8'h00);
        push_word(REQ_READ,   8'h04, 8'h00, 3'd0, 8'h00);   // just past the window
        push_word(REQ_WRITE,  8'hFF, 8'hAA, 3'd0, 8'h00);
        push_word(REQ_CLEAR,  8'h00, 8'h00, 3'd0, 8'h00);
        push_word(REQ_READ,   8'h00, 8'h00, 3'd0, 8'h00);

        // window touching the top of the address space
        program_board(1'b1, 8'hF0, 3'd4);
        push_word(REQ_WRITE,  8'hFE, 8'h04, 3'd0, 8'h00);
        push_word(REQ_ARRIVE, 8'h00, 8'h00, 3'd7, 8'h5A);
        push_word(REQ_READ,   8'hFF, 8'h00, 3'd0, 8'h00);
        push_word(REQ_WRITE,  8'hFF, 8'h00, 3'd0, 8'h00);
        push_word(REQ_READ,   8'hEF, 8'h00, 3'd0, 8'h00);
        push_word(REQ_ARRIVE, 8'h00, 8'h00, 3'd6, 8'h81);
        push_word(REQ_READ,   8'hFC, 8'h00, 3'd0, 8'h00);

        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0: program_board(1'b1, 8'h00, 3'd4);
                1: program_board(1'b1, 8'hF0, 3'd4);
                2: program_board(1'b0, 8'h40, 3'd2);
                3: program_board(1'b1, 8'h80, 3'd0);
                4: program_board(1'b1, 8'h30, 3'd7);
                5: program_board(1'b1, 8'hF8, 3'd3);
                default:
                    program_board($urandom_range(9) != 0,
                                  ($urandom_range(3) == 0) ? ADDR_W'($urandom_range(255))
                                                           : ADDR_W'($urandom_range(15) << 4),
                                  ($urandom_range(4) == 0) ? PORTS_W'($urandom_range(7))
                                                           : PORTS_W'($urandom_range(1, 4)));
            endcase
            sender_idle_pct = (p < 4) ? 12 : (p < 8) ? 88 : 0;
            receiver_idle_pct = (p < 4) ? 88 : (p < 8) ? 12 : 0;
            repeat (160) bus_words.insert(bus_words.size(), random_word());
        end

        settle();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/qppr_pkg.sv
design/qppr_decode.sv
design/qppr_sections.sv
design/quad_parallel_port_registers.sv
test/quad_parallel_port_registers_tb.sv
